>>> hw/rtl/pep_pkg.sv
// Shared types and constants for the palette expand and RGB888 packer.
// No dependencies; imported by every module of the block but pep_ram.
`default_nettype none
package pep_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned ColorW = 24;
    localparam int unsigned WordW  = 32;

    localparam logic CmdPalWrite = 1'b0;
    localparam logic CmdPixel    = 1'b1;

    // Position of a pixel in its group of four.
    localparam logic [1:0] PhaseFirst  = 2'd0;
    localparam logic [1:0] PhaseSecond = 2'd1;
    localparam logic [1:0] PhaseThird  = 2'd2;
    localparam logic [1:0] PhaseFourth = 2'd3;

    typedef struct packed {
        logic             cmd;
        logic [ByteW-1:0] pal_entry;
        logic [ByteW-1:0] red;
        logic [ByteW-1:0] green;
        logic [ByteW-1:0] blue;
        logic [ByteW-1:0] pixel_index;
    } t_in_item;

    typedef struct packed {
        logic [WordW-1:0] data_word;
        logic             burst_last;
    } t_out_item;

    // Request from the top level to the palette lookup.
    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [ByteW-1:0]  wr_entry;
        logic [ColorW-1:0] wr_color;
        logic [ByteW-1:0]  rd_index;
    } t_lkp_req;

endpackage
`default_nettype wire

>>> hw/rtl/palette_expand_rgb888_packer.sv
// Channel | Direction | Payload    | Handshake
// input   | in        | t_in_item  | i_valid / o_ready
// output  | out       | t_out_item | o_valid / i_ready
//
// One item is accepted per cycle while o_ready is high. A pixel reads the palette
// RAM at its accept edge and is packed in the next cycle unless the output stalls;
// any word it completes is then registered in the output register. A palette
// write lands at its accept edge. Reset is synchronous and clears the palette
// through per-entry valid bits, so no clearing pass is needed. A stalled output
// holds the packing stage and, with it, o_ready; the output register lets a new
// pixel enter while a word waits. Depends on pep_pkg, pep_lookup and pep_packer.
`default_nettype none
module palette_expand_rgb888_packer
    import pep_pkg::*;
#(
    parameter int unsigned PALETTE_DEPTH = 256,
    parameter int unsigned BURST_WORDS   = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item
);

    t_lkp_req          w_req;
    logic              w_acc;
    logic              w_adv;
    logic [ColorW-1:0] w_color;

    assign o_ready = w_adv && i_rst_n;
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        w_req.wr       = w_acc && (i_item.cmd == CmdPalWrite);
        w_req.rd       = w_acc && (i_item.cmd == CmdPixel);
        w_req.wr_entry = i_item.pal_entry;
        w_req.wr_color = {i_item.red, i_item.green, i_item.blue};
        w_req.rd_index = i_item.pixel_index;
    end

    pep_lookup #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_color (w_color)
    );

    pep_packer #(
        .BURST_WORDS (BURST_WORDS)
    ) u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_req.rd),
        .i_color (w_color),
        .o_adv   (w_adv),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule
`default_nettype wire

>>> hw/rtl/pep_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module pep_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds while no read is issued.
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/pep_lookup.sv
// Palette store: RAM plus per-entry valid bits so the palette reads zero after reset.
// Depends on pep_pkg and pep_ram.
`default_nettype none
module pep_lookup
    import pep_pkg::*;
#(
    parameter int unsigned PALETTE_DEPTH = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_lkp_req          i_req,
    output logic      [ColorW-1:0] o_color
);

    localparam int unsigned AW = $clog2(PALETTE_DEPTH);

    logic [PALETTE_DEPTH-1:0] r_vld;
    logic                     r_hit;
    logic [ColorW-1:0]        w_rdata;
    logic                     w_wr_in;
    logic                     w_rd_in;
    logic [AW-1:0]            w_waddr;
    logic [AW-1:0]            w_raddr;

    assign w_wr_in = {1'b0, i_req.wr_entry} < (ByteW+1)'(PALETTE_DEPTH);
    assign w_rd_in = {1'b0, i_req.rd_index} < (ByteW+1)'(PALETTE_DEPTH);
    assign w_waddr = i_req.wr_entry[AW-1:0];
    assign w_raddr = i_req.rd_index[AW-1:0];

    pep_ram #(
        .WIDTH (ColorW),
        .DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr && w_wr_in),
        .i_waddr (w_waddr),
        .i_wdata (i_req.wr_color),
        .i_re    (i_req.rd),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // A write lands at its accept edge, so a later pixel read of an in-range entry always sees it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_hit <= 1'b0;
        end else begin
            if (i_req.wr && w_wr_in) begin
                r_vld[w_waddr] <= 1'b1;
            end
            if (i_req.rd) begin
                r_hit <= w_rd_in && r_vld[w_raddr];
            end
        end
    end

    assign o_color = r_hit ? w_rdata : '0;

endmodule
`default_nettype wire

>>> hw/rtl/pep_packer.sv
// Packs looked-up 24-bit colors into 32-bit words and flags burst ends.
// Depends on pep_pkg.
`default_nettype none
module pep_packer
    import pep_pkg::*;
#(
    parameter int unsigned BURST_WORDS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [ColorW-1:0] i_color,
    output logic                   o_adv,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_out_item              o_item
);

    localparam int unsigned BCW = (BURST_WORDS > 1) ? $clog2(BURST_WORDS) : 1;
    localparam logic [BCW-1:0] LastCount = BCW'(BURST_WORDS - 1);

    logic              r_s1_vld;
    logic [1:0]        r_phase, n_phase;
    logic [ColorW-1:0] r_carry, n_carry;
    logic [BCW-1:0]    r_count;
    logic [WordW-1:0]  n_word;
    logic              w_emit;
    logic              w_fire;
    logic              w_last;

    assign w_emit = r_s1_vld && (r_phase != PhaseFirst);
    // The stage moves on unless it has a word and the output register stays full.
    assign o_adv  = !w_emit || !o_valid || i_ready;
    assign w_fire = r_s1_vld && o_adv;
    assign w_last = (r_count == LastCount);

    always_comb begin
        n_word  = '0;
        n_carry = r_carry;
        n_phase = r_phase + 2'd1;
        case (r_phase)
            PhaseFirst: begin
                n_carry = i_color;
            end
            PhaseSecond: begin
                n_word  = {i_color[7:0], r_carry[23:0]};
                n_carry = {8'h00, i_color[23:8]};
            end
            PhaseThird: begin
                n_word  = {i_color[15:0], r_carry[15:0]};
                n_carry = {16'h0000, i_color[23:16]};
            end
            PhaseFourth: begin
                n_word  = {i_color, r_carry[7:0]};
                n_carry = '0;
            end
            default: begin
                n_phase = PhaseFirst;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_phase  <= PhaseFirst;
            r_carry  <= '0;
            r_count  <= '0;
            o_valid  <= 1'b0;
        end else begin
            if (o_adv) begin
                r_s1_vld <= i_take;
            end
            if (w_fire) begin
                r_phase <= n_phase;
                r_carry <= n_carry;
            end
            if (w_fire && w_emit) begin
                o_valid           <= 1'b1;
                o_item.data_word  <= n_word;
                o_item.burst_last <= w_last;
                r_count           <= w_last ? '0 : r_count + BCW'(1);
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/pep_checker.sv
// Port-level checks for the palette expand and RGB888 packer, with its bind.
// Depends on pep_pkg; binds to palette_expand_rgb888_packer.
`default_nettype none
module pep_checker
    import pep_pkg::*;
#(
    parameter int unsigned BURST_WORDS = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire logic      o_ready,
    input  wire t_in_item  i_item,
    input  wire logic      o_valid,
    input  wire logic      i_ready,
    input  wire t_out_item o_item
);

    // A word waiting on the output keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("output transaction changed while stalled");

    // A newly valid word must trace back to an accepted pixel transaction.
    a_word_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready && (i_item.cmd == CmdPixel), 2))
        else $error("word appeared without a pixel transaction");

    // No transaction is taken in or shown while reset is applied.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && ($past(o_ready) == 1'b0))
        else $error("activity during reset");

    // With one-word bursts every word ends a burst.
    a_single_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (BURST_WORDS == 1) |-> o_item.burst_last)
        else $error("one-word burst not flagged");

endmodule

bind palette_expand_rgb888_packer pep_checker #(
    .BURST_WORDS (BURST_WORDS)
) u_pep_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);
`default_nettype wire
